// ===== src/hash_bucket_table_defines.svh =====
// ----------------------------------------------------------------------------
// hash_bucket_table_defines.svh
// Assertion macros shared by the bucket table modules.
// ----------------------------------------------------------------------------
`ifndef HASH_BUCKET_TABLE_DEFINES_SVH
`define HASH_BUCKET_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define HBT_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hash bucket table assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define HBT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hash bucket table assertion failed");
`else
`define HBT_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define HBT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== src/hbt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbt_pkg
// Field widths, request and status codes, register indexes and the
// command bundle shared by the bucket table modules.
// ----------------------------------------------------------------------------
package hbt_pkg;

    localparam int REQ_W       = 3;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 6;
    localparam int OCC_OUT_W   = 4;
    localparam int CAP_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 6'd32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEEPEN  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SHALLOW = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DEPTH = 4'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic compare;    // match keys and find the lowest free slot
        logic apply;      // update the slots and load the result register
    } t_dp_cmd;

endpackage

// ===== src/hbt_if.sv =====
// ----------------------------------------------------------------------------
// hbt_if
// Channel interfaces of the bucket table: request, result and configuration.
// ----------------------------------------------------------------------------
interface hbt_req_if;
    logic                              valid;
    logic                              ready;
    logic        [hbt_pkg::REQ_W-1:0]  req_type;
    logic signed [hbt_pkg::KEY_W-1:0]  key;
    logic        [hbt_pkg::DATA_W-1:0] data_word;

    modport source (output valid, req_type, key, data_word, input ready);
    modport sink   (input valid, req_type, key, data_word, output ready);
endinterface

interface hbt_res_if;
    logic                                valid;
    logic                                ready;
    logic [hbt_pkg::STATUS_W-1:0]        status;
    logic [hbt_pkg::DATA_W-1:0]          found_value;
    logic [hbt_pkg::DEPTH_W-1:0]         local_depth;
    logic [hbt_pkg::OCC_OUT_W-1:0]       occupancy;
    logic                                is_full;
    logic                                is_empty;

    modport source (output valid, status, found_value, local_depth, occupancy,
                    is_full, is_empty, input ready);
    modport sink   (input valid, status, found_value, local_depth, occupancy,
                    is_full, is_empty, output ready);
endinterface

interface hbt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hbt_pkg::CFG_IDX_W-1:0]    index;
    logic [hbt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/hbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbt_ctrl
// Request sequencer: capture, compare, apply, and the result valid flag.
// ----------------------------------------------------------------------------
`include "hash_bucket_table_defines.svh"

module hbt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hbt_pkg::t_dp_cmd o_cmd
);
    import hbt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_acc, out_take, apply_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    // The result register must be free, or be emptied in this same cycle.
    assign apply_ok    = (r_state == S_APPLY) && (!r_out_valid || out_take);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load_req = in_acc;
    assign o_cmd.compare  = (r_state == S_CMP);
    assign o_cmd.apply    = apply_ok;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (apply_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (apply_ok) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `HBT_ASSERT_NEXT(a_acc_to_cmp, i_clk, i_rst_n, in_acc, r_state == S_CMP)
    `HBT_ASSERT_NEXT(a_cmp_to_apply, i_clk, i_rst_n, r_state == S_CMP, r_state == S_APPLY)
    `HBT_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, o_cmd.apply, !r_out_valid || i_out_ready)

endmodule

// ===== src/hbt_datapath.sv =====
// ----------------------------------------------------------------------------
// hbt_datapath
// Slot storage, parallel key match, lowest free slot search, depth and
// configuration registers, and the result register.
// ----------------------------------------------------------------------------
`include "hash_bucket_table_defines.svh"

module hbt_datapath #(
    parameter int BUCKET_SLOTS = 8,
    parameter int VALUE_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hbt_pkg::t_dp_cmd                   i_cmd,
    input  logic        [hbt_pkg::REQ_W-1:0]   i_req_type,
    input  logic signed [hbt_pkg::KEY_W-1:0]   i_key,
    input  logic        [hbt_pkg::DATA_W-1:0]  i_data_word,
    input  logic                               i_cfg_we,
    input  logic        [hbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [hbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        [hbt_pkg::STATUS_W-1:0]   o_status,
    output logic        [hbt_pkg::DATA_W-1:0]     o_found_value,
    output logic        [hbt_pkg::DEPTH_W-1:0]    o_local_depth,
    output logic        [hbt_pkg::OCC_OUT_W-1:0]  o_occupancy,
    output logic                               o_is_full,
    output logic                               o_is_empty
);
    import hbt_pkg::*;

    localparam int IDX_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int OCC_W = $clog2(BUCKET_SLOTS + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(BUCKET_SLOTS);

    // Captured request.
    logic        [REQ_W-1:0]      r_req;
    logic signed [KEY_W-1:0]      r_key;
    logic        [VALUE_BITS-1:0] r_data;

    // Slots.
    logic        [BUCKET_SLOTS-1:0] r_valid, n_valid;
    logic signed [KEY_W-1:0]        r_slot_key   [BUCKET_SLOTS];
    logic        [VALUE_BITS-1:0]   r_slot_value [BUCKET_SLOTS];
    logic        [OCC_W-1:0]        r_occ, n_occ;
    logic        [DEPTH_W-1:0]      r_depth, n_depth;
    logic        [CAP_W-1:0]        r_cap;

    // Compare stage results.
    logic [BUCKET_SLOTS-1:0] match_vec;
    logic [IDX_W-1:0]        match_idx, free_idx;
    logic                    r_hit;
    logic [IDX_W-1:0]        r_hit_idx, r_free_idx;

    // Apply stage.
    logic [CMP_W-1:0]      eff_cap;
    logic [STATUS_W-1:0]   n_status;
    logic [VALUE_BITS-1:0] n_found;
    logic                  key_we, val_we;
    logic [IDX_W-1:0]      wr_idx;

    // Result register.
    logic [STATUS_W-1:0]   r_res_status;
    logic [VALUE_BITS-1:0] r_res_found;
    logic [DEPTH_W-1:0]    r_res_depth;
    logic [OCC_W-1:0]      r_res_occ;
    logic                  r_res_full;

    // Keys are unique among valid slots, so at most one slot matches and
    // the index is a plain OR of the matching positions.
    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < BUCKET_SLOTS; i++) begin
            match_vec[i] = r_valid[i] && (r_slot_key[i] == r_key);
            if (match_vec[i]) begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
        for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Capacity saturated into 1..BUCKET_SLOTS.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > SLOTS_C) begin
            eff_cap = SLOTS_C;
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    always_comb begin
        n_valid  = r_valid;
        n_occ    = r_occ;
        n_depth  = r_depth;
        n_status = ST_OK;
        n_found  = '0;
        key_we   = 1'b0;
        val_we   = 1'b0;
        wr_idx   = r_hit_idx;
        case (r_req)
            REQ_INSERT: begin
                if (r_hit) begin
                    n_status = ST_DUP;
                end else if (CMP_W'(r_occ) >= eff_cap) begin
                    n_status = ST_FULL;
                end else begin
                    n_valid[r_free_idx] = 1'b1;
                    n_occ  = r_occ + OCC_W'(1);
                    key_we = 1'b1;
                    val_we = 1'b1;
                    wr_idx = r_free_idx;
                end
            end
            REQ_REMOVE: begin
                if (r_hit) begin
                    n_valid[r_hit_idx] = 1'b0;
                    n_occ = r_occ - OCC_W'(1);
                end else begin
                    n_status = ST_MISS;
                end
            end
            REQ_UPDATE: begin
                if (r_hit) begin
                    val_we = 1'b1;
                end else begin
                    n_status = ST_MISS;
                end
            end
            REQ_SEARCH: begin
                if (r_hit) begin
                    n_found = r_slot_value[r_hit_idx];
                end else begin
                    n_status = ST_MISS;
                end
            end
            REQ_CLEAR: begin
                n_valid = '0;
                n_occ   = '0;
            end
            REQ_DEEPEN: begin
                if (r_depth < DEPTH_MAX) begin
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end
            REQ_SHALLOW: begin
                if (r_depth != '0) begin
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Request capture and compare results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req_type;
            r_key  <= i_key;
            r_data <= VALUE_BITS'(i_data_word);
        end
        if (i_cmd.compare) begin
            r_hit      <= |match_vec;
            r_hit_idx  <= match_idx;
            r_free_idx <= free_idx;
        end
    end

    // Slot payload; no reset, read only behind a valid bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && key_we) begin
            r_slot_key[wr_idx] <= r_key;
        end
        if (i_cmd.apply && val_we) begin
            r_slot_value[wr_idx] <= r_data;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_depth <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cmd.apply) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                r_depth <= n_depth;
            end
            if (i_cfg_we && (i_cfg_index == CFG_CAPACITY)) begin
                r_cap <= i_cfg_data[CAP_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_INIT_DEPTH)) begin
                if (i_cfg_data[DEPTH_W-1:0] > DEPTH_MAX) begin
                    r_depth <= DEPTH_MAX;
                end else begin
                    r_depth <= i_cfg_data[DEPTH_W-1:0];
                end
            end
        end
    end

    // Result register, loaded with the state after the request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res_status <= n_status;
            r_res_found  <= n_found;
            r_res_depth  <= n_depth;
            r_res_occ    <= n_occ;
            r_res_full   <= (CMP_W'(n_occ) >= eff_cap);
        end
    end

    assign o_status      = r_res_status;
    assign o_found_value = DATA_W'(r_res_found);
    assign o_local_depth = r_res_depth;
    assign o_occupancy   = OCC_OUT_W'(r_res_occ);
    assign o_is_full     = r_res_full;
    assign o_is_empty    = (r_res_occ == '0);

    `HBT_ASSERT_IMPLY(a_occ_count, i_clk, i_rst_n, 1'b1, $countones(r_valid) == int'(r_occ))
    `HBT_ASSERT_IMPLY(a_match_unique, i_clk, i_rst_n, i_cmd.compare, $onehot0(match_vec))
    `HBT_ASSERT_IMPLY(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_MAX)

endmodule

// ===== src/hash_bucket_table.sv =====
// ----------------------------------------------------------------------------
// hash_bucket_table
// One bucket of an extendible hash table: key/value slots with a local depth.
// ----------------------------------------------------------------------------
// Each request beat (insert, remove, update, search, clear, deepen, shallow)
// gives exactly one result beat. A request is captured, the keys of all valid
// slots are then matched against it in parallel, and then the slots and the
// result register are updated, in the controller's capture, compare and apply
// sequence; a new request is taken only once the last one is applied. The
// result waits in an output register, and the next request is already taken
// and matched while it waits; only the apply step holds off until the result
// register is free. Insert reports a duplicate key before a full bucket and
// fills the lowest free slot. Clear empties every slot but keeps the depth.
// The depth saturates at 0 and 32.
// Configuration writes (register 0 capacity, register 1 initial depth, which
// loads the depth at once) are always ready and must be made while idle.
// ----------------------------------------------------------------------------
module hash_bucket_table #(
    parameter int BUCKET_SLOTS = 8,
    parameter int VALUE_BITS   = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hbt_req_if.sink   i_req,
    hbt_res_if.source o_res,
    hbt_cfg_if.sink   i_cfg
);
    import hbt_pkg::*;

    t_dp_cmd cmd;

    // Configuration writes complete in the cycle they are offered.
    assign i_cfg.ready = 1'b1;

    // The controller owns the request and result handshakes; the datapath never sees them.
    hbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    hbt_datapath #(
        .BUCKET_SLOTS (BUCKET_SLOTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req.req_type),
        .i_key         (i_req.key),
        .i_data_word   (i_req.data_word),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_status      (o_res.status),
        .o_found_value (o_res.found_value),
        .o_local_depth (o_res.local_depth),
        .o_occupancy   (o_res.occupancy),
        .o_is_full     (o_res.is_full),
        .o_is_empty    (o_res.is_empty)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for one hash bucket: request, result and configuration
// channels driven from plain tasks, every result beat checked against a
// scoreboard that tracks the slots, the depth and the capacity on its own.
// ----------------------------------------------------------------------------
module testbench;

    import hbt_pkg::*;

    localparam int SLOTS        = 8;
    localparam int POOL_MAX     = 12;
    // Cycles of silence on every channel before the run is declared hung.
    localparam int STALL_LIMIT  = 3000;
    // Long receiver hold-off that lets the bucket back up onto its input.
    localparam int HOLD_CYCLES  = 300;
    // Cycles allowed after the last awaited result before a register changes.
    localparam int SETTLE       = 6;
    localparam int END_SETTLE   = 10;

    // Request code 7 is not named by the package; the bucket treats it as a
    // no-op that still returns a result beat.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [DATA_W-1:0]    found_value;
        logic [DEPTH_W-1:0]   local_depth;
        logic [OCC_OUT_W-1:0] occupancy;
        logic                 is_full;
        logic                 is_empty;
    } t_bucket_result;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the bucket. Each accepted request beat is
    // applied to it at once and the resulting beat is queued; result beats
    // are checked in order against that queue.
    // ------------------------------------------------------------------------
    class t_bucket_scoreboard;
        logic                slot_used[SLOTS];
        logic [KEY_W-1:0]    slot_key[SLOTS];
        logic [DATA_W-1:0]   slot_value[SLOTS];
        logic [DEPTH_W-1:0]  depth;
        logic [CAP_W-1:0]    capacity;
        t_bucket_result      awaited_results[$];
        int                  error_count;

        function void clear_state();
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
            end
            depth       = '0;
            capacity    = CAP_RESET;
            error_count = 0;
            awaited_results.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_CAPACITY) begin
                capacity = val[CAP_W-1:0];
            end else if (idx == CFG_INIT_DEPTH) begin
                depth = (val[DEPTH_W-1:0] > DEPTH_MAX) ? DEPTH_MAX : val[DEPTH_W-1:0];
            end
        endfunction

        // Capacity is clamped into 1..SLOTS before it is used.
        function int unsigned effective_capacity();
            if (capacity == 0) return 1;
            if (capacity > SLOTS) return SLOTS;
            return 32'(capacity);
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] k,
                                   logic [DATA_W-1:0] d);
            t_bucket_result res;
            int             hit;
            int             free_slot;
            int unsigned    occ;
            hit       = -1;
            free_slot = -1;
            occ       = 0;
            foreach (slot_used[i]) begin
                if (slot_used[i]) begin
                    occ++;
                    if (hit < 0 && slot_key[i] == k) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            res        = '0;
            res.status = ST_OK;
            case (req)
                REQ_INSERT: begin
                    // A duplicate key wins over a full bucket.
                    if (hit >= 0) begin
                        res.status = ST_DUP;
                    end else if (occ >= effective_capacity()) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_used[free_slot]  = 1'b1;
                        slot_key[free_slot]   = k;
                        slot_value[free_slot] = d;
                    end
                end
                REQ_REMOVE: begin
                    if (hit >= 0) slot_used[hit] = 1'b0;
                    else res.status = ST_MISS;
                end
                REQ_UPDATE: begin
                    if (hit >= 0) slot_value[hit] = d;
                    else res.status = ST_MISS;
                end
                REQ_SEARCH: begin
                    if (hit >= 0) res.found_value = slot_value[hit];
                    else res.status = ST_MISS;
                end
                REQ_CLEAR: begin
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                end
                REQ_DEEPEN: begin
                    if (depth < DEPTH_MAX) depth = depth + 1'b1;
                end
                REQ_SHALLOW: begin
                    if (depth != 0) depth = depth - 1'b1;
                end
                default: begin
                end
            endcase
            occ = 0;
            foreach (slot_used[i]) if (slot_used[i]) occ++;
            res.local_depth = depth;
            res.occupancy   = OCC_OUT_W'(occ);
            res.is_full     = (occ >= effective_capacity());
            res.is_empty    = (occ == 0);
            awaited_results.push_back(res);
        endfunction

        function void check_result(t_bucket_result got);
            t_bucket_result want;
            if (awaited_results.size() == 0) begin
                $error("result beat with no request outstanding (status %0d)", got.status);
                error_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                error_count++;
            end
            if (got.found_value !== want.found_value) begin
                $error("found_value: expected %h, actual %h",
                       want.found_value, got.found_value);
                error_count++;
            end
            if (got.local_depth !== want.local_depth) begin
                $error("local_depth: expected %0d, actual %0d",
                       want.local_depth, got.local_depth);
                error_count++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                error_count++;
            end
            if (got.is_full !== want.is_full) begin
                $error("is_full: expected %0d, actual %0d", want.is_full, got.is_full);
                error_count++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hbt_req_if req_if ();
    hbt_res_if res_if ();
    hbt_cfg_if cfg_if ();

    hash_bucket_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_bucket_scoreboard bucket_sb;

    // Idle rates in percent, set per phase by the stimulus process.
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    // Set by the stimulus process, counted down by the receiver process.
    int          rx_hold_len;

    // Keys are mostly drawn from a small pool so that hits, duplicates and
    // full buckets come up often; the pool always holds the key extremes.
    logic [KEY_W-1:0] key_pool[POOL_MAX];
    int               pool_size;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: checks each accepted result beat and drives ready. A hold-off
    // requested by the stimulus process is counted down here, cycle by cycle.
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        t_bucket_result got;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.status      = res_if.status;
                got.found_value = res_if.found_value;
                got.local_depth = res_if.local_depth;
                got.occupancy   = res_if.occupancy;
                got.is_full     = res_if.is_full;
                got.is_empty    = res_if.is_empty;
                bucket_sb.check_result(got);
            end
            if (rx_hold_len > 0) begin
                rx_hold_len--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no channel has moved a beat for too long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL hash_bucket_table");
        $finish;
    end

    // Offers one request beat, after a random gap, and returns at the edge
    // where it is accepted. Valid is left high so that a following beat can
    // go out back to back.
    task automatic offer_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] k,
                                 input logic [DATA_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= req;
        req_if.key       <= k;
        req_if.data_word <= d;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        bucket_sb.note_request(req, k, d);
    endtask

    // Stops offering and waits for every awaited result beat, then lets the
    // given number of extra cycles pass. At least one edge always passes, so
    // valid is never lowered and raised within one time step.
    task automatic drain_bucket(input int settle);
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (bucket_sb.awaited_results.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes capacity and then initial depth as two back-to-back beats.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] cap_byte,
                                  input logic [CFG_DATA_W-1:0] depth_byte);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_CAPACITY;
        cfg_if.data  <= cap_byte;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        bucket_sb.write_reg(CFG_CAPACITY, cap_byte);
        cfg_if.index <= CFG_INIT_DEPTH;
        cfg_if.data  <= depth_byte;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        bucket_sb.write_reg(CFG_INIT_DEPTH, depth_byte);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic refresh_key_pool();
        pool_size   = $urandom_range(4, POOL_MAX);
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_MAX; i++) key_pool[i] = $urandom;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(pool_size - 1)];
        return $urandom;
    endfunction

    // One random request, weighted toward insert and search so that the
    // bucket fills, hits and overflows regularly.
    task automatic send_random_request();
        int unsigned      roll;
        logic [REQ_W-1:0] req;
        roll = $urandom_range(99);
        if (roll < 30)      req = REQ_INSERT;
        else if (roll < 45) req = REQ_REMOVE;
        else if (roll < 57) req = REQ_UPDATE;
        else if (roll < 82) req = REQ_SEARCH;
        else if (roll < 85) req = REQ_CLEAR;
        else if (roll < 92) req = REQ_DEEPEN;
        else if (roll < 99) req = REQ_SHALLOW;
        else                req = REQ_UNUSED;
        offer_request(req, pick_key(), $urandom);
    endtask

    // One phase: settle, new register values (random upper bits in each data
    // byte), idle pattern, fresh key pool, then random traffic. Optionally the
    // receiver holds off for a long stretch early on, or the sender pauses
    // halfway until every result has come back.
    task automatic run_phase(input logic [CAP_W-1:0] cap, input logic [DEPTH_W-1:0] dep,
                             input t_idle_mode mode, input int count,
                             input bit with_hold, input bit with_pause);
        logic [CFG_DATA_W-1:0] cap_byte;
        logic [CFG_DATA_W-1:0] depth_byte;
        cap_byte   = {4'($urandom_range(15)), cap};
        depth_byte = {2'($urandom_range(3)), dep};
        drain_bucket(SETTLE);
        write_settings(cap_byte, depth_byte);
        case (mode)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SEND: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
            IDLE_RECV: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
            default:   begin tx_idle_pct = 32; rx_stall_pct = 32; end
        endcase
        refresh_key_pool();
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == 8) rx_hold_len = HOLD_CYCLES;
            if (with_pause && n == count / 2) drain_bucket(0);
            send_random_request();
        end
    endtask

    // Directed opening: misses on an empty bucket, depth floor, key extremes,
    // duplicate against full priority, lowest-free-slot reuse, the unused
    // request code, then capacity lowered below occupancy and the depth ceiling.
    task automatic run_directed();
        offer_request(REQ_SEARCH,  32'h0000_0000, $urandom);
        offer_request(REQ_REMOVE,  32'h0000_0005, $urandom);
        offer_request(REQ_UPDATE,  32'h0000_0005, $urandom);
        offer_request(REQ_SHALLOW, $urandom, $urandom);
        offer_request(REQ_INSERT,  32'h8000_0000, 32'h0000_0000);
        offer_request(REQ_INSERT,  32'h7fff_ffff, 32'hffff_ffff);
        offer_request(REQ_INSERT,  32'h8000_0000, 32'h0000_0001);
        offer_request(REQ_SEARCH,  32'h7fff_ffff, $urandom);
        offer_request(REQ_UPDATE,  32'h8000_0000, 32'ha5a5_a5a5);
        offer_request(REQ_SEARCH,  32'h8000_0000, $urandom);
        offer_request(REQ_REMOVE,  32'h7fff_ffff, $urandom);
        // The freed second slot must be the one this insert takes.
        offer_request(REQ_INSERT,  32'hffff_ffff, 32'h5a5a_5a5a);
        for (int i = 0; i < 6; i++) offer_request(REQ_INSERT, i, $urandom);
        offer_request(REQ_INSERT,  32'h0000_0006, $urandom);
        offer_request(REQ_INSERT,  32'h0000_0000, $urandom);
        offer_request(REQ_UNUSED,  $urandom, $urandom);
        offer_request(REQ_DEEPEN,  $urandom, $urandom);
        // Eight slots in use, capacity now three: the slots stay, the bucket
        // reads as full until removals bring it under three.
        drain_bucket(SETTLE);
        write_settings(8'h03, 8'd31);
        offer_request(REQ_INSERT,  32'h0000_0007, $urandom);
        offer_request(REQ_REMOVE,  32'h0000_0000, $urandom);
        offer_request(REQ_DEEPEN,  $urandom, $urandom);
        offer_request(REQ_DEEPEN,  $urandom, $urandom);
        offer_request(REQ_CLEAR,   $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus: reset, directed beats, then phases that step through the
    // register extremes and every idle pattern, then random phases.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        bucket_sb = new;
        bucket_sb.clear_state();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_len  = 0;
        pool_size    = 4;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= REQ_INSERT;
        req_if.key       <= '0;
        req_if.data_word <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_CAPACITY;
        cfg_if.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        run_phase(4'd8,  6'd0,  IDLE_NONE, 150, 1'b1, 1'b0);
        run_phase(4'd1,  6'd32, IDLE_SEND, 120, 1'b0, 1'b0);
        run_phase(4'd0,  6'd63, IDLE_RECV, 120, 1'b0, 1'b0);
        run_phase(4'd15, 6'd31, IDLE_BOTH, 150, 1'b0, 1'b0);
        run_phase(4'd4,  6'd1,  IDLE_NONE, 150, 1'b0, 1'b1);
        run_phase(4'd8,  6'd33, IDLE_SEND, 120, 1'b0, 1'b0);
        run_phase(4'd2,  6'd0,  IDLE_RECV, 120, 1'b0, 1'b0);
        run_phase(4'd9,  6'd16, IDLE_BOTH, 150, 1'b0, 1'b0);
        for (int p = 0; p < 5; p++) begin
            run_phase(CAP_W'($urandom_range(15)), DEPTH_W'($urandom_range(63)),
                      t_idle_mode'($urandom_range(3)), 110, 1'b0, 1'b0);
        end

        drain_bucket(END_SETTLE);
        if (bucket_sb.error_count == 0) begin
            $display("PASS hash_bucket_table");
        end else begin
            $display("FAIL hash_bucket_table");
        end
        $finish;
    end

endmodule

// ===== hash_bucket_table.f =====
+incdir+src
src/hbt_pkg.sv
src/hbt_if.sv
src/hbt_ctrl.sv
src/hbt_datapath.sv
src/hash_bucket_table.sv
verif/testbench.sv
